[src/bmhpq_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmhpq_pkg - shared definitions for the binary max-heap priority queue
// Operation and status codes, field widths and the result record that the
// heap sequencer hands to the output stage.
// ----------------------------------------------------------------------------
package bmhpq_pkg;

	// default number of heap entries
	localparam int CAPACITY_DEF = 16;

	// field widths
	localparam int VAL_W = 32;
	localparam int OP_W  = 2;
	localparam int STS_W = 2;
	localparam int CNT_W = 5;

	// operation codes
	localparam logic [OP_W-1:0] OP_INSERT  = 2'd0;
	localparam logic [OP_W-1:0] OP_REMOVE  = 2'd1;
	localparam logic [OP_W-1:0] OP_APPEND  = 2'd2;
	localparam logic [OP_W-1:0] OP_HEAPIFY = 2'd3;

	// status codes
	localparam logic [STS_W-1:0] STS_OK    = 2'd0;
	localparam logic [STS_W-1:0] STS_EMPTY = 2'd1;
	localparam logic [STS_W-1:0] STS_FULL  = 2'd2;

	// one result transaction
	typedef struct packed {
		logic signed [VAL_W-1:0] removed_value;
		logic [STS_W-1:0]        status;
		logic [CNT_W-1:0]        count;
		logic signed [VAL_W-1:0] root_value;
	} res_t;

endpackage

[src/binary_max_heap_priority_queue_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary_max_heap_priority_queue_unit - max-heap priority queue
// Insert, remove max, unordered append and full heapify on a store of signed
// 32-bit values; one result transaction per request transaction.
//
//   channel | signals                                        | dir
//   --------+------------------------------------------------+-----
//   req     | req_valid, req_stall, op, value                | in
//   rsp     | rsp_valid, rsp_stall, removed_value, status,   | out
//           | count, root_value                              |
//
// One request at a time. Append and the full or empty cases go straight to
// the done step; insert moves the new value up one parent at a time until it
// meets a parent that is not smaller or reaches the root; remove and heapify
// sift an element down one level at a time. The pace is set by the single
// read port of the heap memory, one registered read per cycle. Reset empties
// the heap at once; no clearing pass. A new request is taken while the
// previous result waits in the output register; a stalled result holds the
// sequencer in its done step.
// ----------------------------------------------------------------------------
module binary_max_heap_priority_queue_unit #(
	parameter int CAPACITY = bmhpq_pkg::CAPACITY_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 req_valid,
	output logic                                 req_stall,
	input  logic [bmhpq_pkg::OP_W-1:0]           op,
	input  logic signed [bmhpq_pkg::VAL_W-1:0]   value,
	output logic                                 rsp_valid,
	input  logic                                 rsp_stall,
	output logic signed [bmhpq_pkg::VAL_W-1:0]   removed_value,
	output logic [bmhpq_pkg::STS_W-1:0]          status,
	output logic [bmhpq_pkg::CNT_W-1:0]          count,
	output logic signed [bmhpq_pkg::VAL_W-1:0]   root_value
);

	logic            idle;
	logic            done;
	logic            take;
	logic            rsp_valid_q;
	bmhpq_pkg::res_t res;
	bmhpq_pkg::res_t res_q;

	bmhpq_core #(
		.CAPACITY (CAPACITY)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (req_valid && idle),
		.op     (op),
		.value  (value),
		.idle   (idle),
		.done   (done),
		.take   (take),
		.res    (res)
	);

	assign req_stall = !idle;

	// output register loads when empty or being drained
	assign take = done && (!rsp_valid_q || !rsp_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (take) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			res_q <= res;
		end
	end

	assign rsp_valid     = rsp_valid_q;
	assign removed_value = res_q.removed_value;
	assign status        = res_q.status;
	assign count         = res_q.count;
	assign root_value    = res_q.root_value;

endmodule

[src/bmhpq_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmhpq_core - heap store and operation sequencer
// Holds the heap in a single-port-write, single-port-read synchronous memory
// and walks it one level at a time. The moving element stays in a register
// (hole method) and is written once when its final position is found.
// ----------------------------------------------------------------------------
module bmhpq_core #(
	parameter int CAPACITY = bmhpq_pkg::CAPACITY_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	input  logic [bmhpq_pkg::OP_W-1:0]           op,
	input  logic signed [bmhpq_pkg::VAL_W-1:0]   value,
	output logic                                 idle,
	output logic                                 done,
	input  logic                                 take,
	output bmhpq_pkg::res_t                      res
);

	localparam int CW = $clog2(CAPACITY + 1);  // element count
	localparam int PW = CW + 1;                // heap position incl. children
	localparam int AW = $clog2(CAPACITY);      // memory address

	localparam logic [3:0] S_IDLE    = 4'd0;
	localparam logic [3:0] S_UP_CHK  = 4'd1;
	localparam logic [3:0] S_UP_CMP  = 4'd2;
	localparam logic [3:0] S_RM_WAIT = 4'd3;
	localparam logic [3:0] S_HP_RD   = 4'd4;
	localparam logic [3:0] S_HP_WAIT = 4'd5;
	localparam logic [3:0] S_DN_L    = 4'd6;
	localparam logic [3:0] S_DN_R    = 4'd7;
	localparam logic [3:0] S_DN_CMP  = 4'd8;
	localparam logic [3:0] S_DN_MV   = 4'd9;
	localparam logic [3:0] S_DN_END  = 4'd10;
	localparam logic [3:0] S_DONE    = 4'd11;

	logic [3:0]                            state_q;
	logic [CW-1:0]                         cnt_q;
	logic [CW-1:0]                         hp_q;
	logic [PW-1:0]                         pos_q;
	logic [PW-1:0]                         bpos_q;
	logic signed [bmhpq_pkg::VAL_W-1:0]    cur_q;
	logic signed [bmhpq_pkg::VAL_W-1:0]    best_q;
	logic signed [bmhpq_pkg::VAL_W-1:0]    root_q;
	logic signed [bmhpq_pkg::VAL_W-1:0]    removed_q;
	logic [bmhpq_pkg::STS_W-1:0]           status_q;
	logic [bmhpq_pkg::OP_W-1:0]            op_q;

	// memory and its ports
	logic signed [bmhpq_pkg::VAL_W-1:0]    mem [CAPACITY];
	logic signed [bmhpq_pkg::VAL_W-1:0]    rdata_q;
	logic signed [bmhpq_pkg::VAL_W-1:0]    wdata;
	logic                                  we;
	logic [PW-1:0]                         wpos;
	logic [PW-1:0]                         rpos;
	logic [PW-1:0]                         wpos_m1;
	logic [PW-1:0]                         rpos_m1;
	logic [AW-1:0]                         waddr;
	logic [AW-1:0]                         raddr;

	// position arithmetic
	logic [PW-1:0]                         cnt_ext;
	logic [PW-1:0]                         left;
	logic [PW-1:0]                         right;
	logic [PW-1:0]                         parent;
	logic                                  full;
	logic [bmhpq_pkg::CNT_W-1:0]           cnt5;

	assign cnt_ext = {1'b0, cnt_q};
	assign left    = {pos_q[PW-2:0], 1'b0};
	assign right   = {pos_q[PW-2:0], 1'b1};
	assign parent  = {1'b0, pos_q[PW-1:1]};
	assign full    = (cnt_ext >= PW'(CAPACITY));

	assign wpos_m1 = wpos - PW'(1);
	assign rpos_m1 = rpos - PW'(1);
	assign waddr   = wpos_m1[AW-1:0];
	assign raddr   = rpos_m1[AW-1:0];

	// memory port control
	always_comb begin
		we    = 1'b0;
		wpos  = PW'(1);
		wdata = cur_q;
		rpos  = PW'(1);
		case (state_q)
			S_IDLE: begin
				if (start && op == bmhpq_pkg::OP_APPEND && !full) begin
					we    = 1'b1;
					wpos  = cnt_ext + PW'(1);
					wdata = value;
				end
				rpos = cnt_ext;
			end
			S_UP_CHK: begin
				if (pos_q == PW'(1)) begin
					we = 1'b1;
				end
				rpos = parent;
			end
			S_UP_CMP: begin
				we   = 1'b1;
				wpos = pos_q;
				if (cur_q > rdata_q) begin
					wdata = rdata_q;
				end
			end
			S_HP_RD: begin
				rpos = {1'b0, hp_q};
			end
			S_DN_L: begin
				if (left > cnt_ext) begin
					we   = 1'b1;
					wpos = pos_q;
				end
				rpos = left;
			end
			S_DN_R: begin
				rpos = right;
			end
			S_DN_MV: begin
				we   = 1'b1;
				wpos = pos_q;
				if (bpos_q != pos_q) begin
					wdata = best_q;
				end
			end
			default: begin
			end
		endcase
	end

	// heap store, registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	// copy of position 1, kept current on every root write
	always_ff @(posedge clk) begin
		if (we && wpos == PW'(1)) begin
			root_q <= wdata;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (start) begin
						op_q      <= op;
						removed_q <= '0;
						status_q  <= bmhpq_pkg::STS_OK;
						case (op)
							bmhpq_pkg::OP_INSERT: begin
								if (full) begin
									status_q <= bmhpq_pkg::STS_FULL;
									state_q  <= S_DONE;
								end else begin
									cnt_q   <= cnt_q + CW'(1);
									cur_q   <= value;
									pos_q   <= cnt_ext + PW'(1);
									state_q <= S_UP_CHK;
								end
							end
							bmhpq_pkg::OP_APPEND: begin
								if (full) begin
									status_q <= bmhpq_pkg::STS_FULL;
								end else begin
									cnt_q <= cnt_q + CW'(1);
								end
								state_q <= S_DONE;
							end
							bmhpq_pkg::OP_REMOVE: begin
								if (cnt_q == '0) begin
									status_q <= bmhpq_pkg::STS_EMPTY;
									state_q  <= S_DONE;
								end else begin
									removed_q <= root_q;
									cnt_q     <= cnt_q - CW'(1);
									pos_q     <= PW'(1);
									state_q   <= S_RM_WAIT;
								end
							end
							default: begin
								hp_q <= cnt_q >> 1;
								if ((cnt_q >> 1) == '0) begin
									state_q <= S_DONE;
								end else begin
									state_q <= S_HP_RD;
								end
							end
						endcase
					end
				end
				// last element arrives; it becomes the moving element at the root
				S_RM_WAIT: begin
					cur_q <= rdata_q;
					if (cnt_q == '0) begin
						state_q <= S_DONE;
					end else begin
						state_q <= S_DN_L;
					end
				end
				S_UP_CHK: begin
					if (pos_q == PW'(1)) begin
						state_q <= S_DONE;
					end else begin
						state_q <= S_UP_CMP;
					end
				end
				// parent moves down when strictly smaller
				S_UP_CMP: begin
					if (cur_q > rdata_q) begin
						pos_q   <= parent;
						state_q <= S_UP_CHK;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_HP_RD: begin
					pos_q   <= {1'b0, hp_q};
					state_q <= S_HP_WAIT;
				end
				S_HP_WAIT: begin
					cur_q   <= rdata_q;
					state_q <= S_DN_L;
				end
				S_DN_L: begin
					if (left > cnt_ext) begin
						state_q <= S_DN_END;
					end else begin
						state_q <= S_DN_R;
					end
				end
				// left child data is here
				S_DN_R: begin
					if (rdata_q > cur_q) begin
						best_q <= rdata_q;
						bpos_q <= left;
					end else begin
						best_q <= cur_q;
						bpos_q <= pos_q;
					end
					if (right > cnt_ext) begin
						state_q <= S_DN_MV;
					end else begin
						state_q <= S_DN_CMP;
					end
				end
				// right child data is here
				S_DN_CMP: begin
					if (rdata_q > best_q) begin
						best_q <= rdata_q;
						bpos_q <= right;
					end
					state_q <= S_DN_MV;
				end
				S_DN_MV: begin
					if (bpos_q == pos_q) begin
						state_q <= S_DN_END;
					end else begin
						pos_q   <= bpos_q;
						state_q <= S_DN_L;
					end
				end
				// next parent for heapify, else finish
				S_DN_END: begin
					if (op_q == bmhpq_pkg::OP_HEAPIFY && hp_q > CW'(1)) begin
						hp_q    <= hp_q - CW'(1);
						state_q <= S_HP_RD;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (take) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// count field is the low five bits
	generate
		if (CW >= bmhpq_pkg::CNT_W) begin : g_cnt_trunc
			assign cnt5 = cnt_q[bmhpq_pkg::CNT_W-1:0];
		end else begin : g_cnt_ext
			assign cnt5 = {{(bmhpq_pkg::CNT_W - CW){1'b0}}, cnt_q};
		end
	endgenerate

	assign idle              = (state_q == S_IDLE);
	assign done              = (state_q == S_DONE);
	assign res.removed_value = removed_q;
	assign res.status        = status_q;
	assign res.count         = cnt5;
	assign res.root_value    = (cnt_q != '0) ? root_q : '0;

endmodule
